// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clock and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_HOLDS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/alc_pkg.sv =====
`default_nettype none
package alc_pkg;

   localparam int ENTRIES_DEF = 6;
   localparam int KEY_W       = 16;
   localparam int TAG_W       = 32;
   localparam int AGE_W       = 31;
   localparam int SLOT_W      = 4;

   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } entry_type;

   // empty entry: key 0, tag 0, age at the empty marker
   localparam entry_type ENTRY_RESET = '{key: '0, tag: '0, age: AGE_MAX};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIX
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/alc_if.sv =====
`default_nettype none
interface alc_req_if;
   import alc_pkg::*;
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key;
   logic [TAG_W-1:0] new_tag;

   modport source (output valid, output key, output new_tag, input ready);
   modport sink   (input valid, input key, input new_tag, output ready);
endinterface

interface alc_rsp_if;
   import alc_pkg::*;
   logic              valid;
   logic              ready;
   logic              hit;
   logic [SLOT_W-1:0] slot;
   logic [TAG_W-1:0]  tag_out;
   logic              evict_valid;
   logic [KEY_W-1:0]  evicted_key;

   modport source (output valid, output hit, output slot, output tag_out,
                   output evict_valid, output evicted_key, input ready);
   modport sink   (input valid, input hit, input slot, input tag_out,
                   input evict_valid, input evicted_key, output ready);
endinterface
`default_nettype wire

// ===== rtl/age_lru_handle_cache.sv =====
// a request is accepted in idle and served by a sweep of the single read port over all
// entries, then a write-back to the hit or victim entry that loads the output register;
// a new request is taken only back in idle, and a waiting result holds the write-back
// reset: synchronous, clears control state and the per-entry valid bits at once, so all
// entries read as empty (key 0, tag 0, age saturated) with no clearing pass
`default_nettype none
module age_lru_handle_cache #(
   parameter  int ENTRIES = alc_pkg::ENTRIES_DEF,
   localparam int IDX_W   = $clog2(ENTRIES),
   localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
   input wire         clock,
   input wire         reset,
   alc_req_if.sink    req_ch,
   alc_rsp_if.source  rsp_ch
);
   import alc_pkg::*;

   // sequencer state
   state_type state_ff, state_in;

   // captured request beat
   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // read sweep: issue counter and the index of the entry now on the read data
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // running search results
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [TAG_W-1:0] hit_tag_ff, hit_tag_in;
   logic [AGE_W-1:0] best_age_ff, best_age_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [KEY_W-1:0] best_key_ff, best_key_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic              rsp_evict_ff, rsp_evict_in;
   logic [KEY_W-1:0]  rsp_ekey_ff, rsp_ekey_in;

   // memory ports
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // control strobes
   logic             req_fire;
   logic             fix_fire;
   logic             scan_last;
   logic [AGE_W-1:0] aged;

   alc_entry_store #(.ENTRIES(ENTRIES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign scan_last = rd_pend_ff && (rd_idx_ff == IDX_W'(ENTRIES - 1));
   assign rd_addr   = rd_cnt_ff[IDX_W-1:0];

   // age of the entry on the read data after this request's increment
   assign aged = (rd_data.age == AGE_MAX) ? AGE_MAX : rd_data.age + AGE_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (fix_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      rd_en        = 1'b0;
      fix_fire     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_SCAN: begin
            rd_en = (rd_cnt_ff < CNT_W'(ENTRIES));
         end
         ST_FIX: begin
            // the output register must be free before the result lands
            fix_fire = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      key_in       = key_ff;
      tag_in       = tag_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_pend_in   = rd_en;
      rd_idx_in    = rd_en ? rd_addr : rd_idx_ff;
      hit_found_in = hit_found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_tag_in   = hit_tag_ff;
      best_age_in  = best_age_ff;
      best_idx_in  = best_idx_ff;
      best_key_in  = best_key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_ekey_in  = rsp_ekey_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_data      = '{key: rd_data.key, tag: rd_data.tag, age: aged};

      if (req_fire) begin
         key_in       = req_ch.key;
         tag_in       = req_ch.new_tag;
         rd_cnt_in    = '0;
         hit_found_in = 1'b0;
         // aged values are never zero, so entry 0 always takes the first compare
         best_age_in  = '0;
         best_idx_in  = '0;
      end

      if (rd_en) begin
         rd_cnt_in = rd_cnt_ff + CNT_W'(1);
      end

      // one entry per cycle: compare key, age it, write it back
      if (state_ff == ST_SCAN && rd_pend_ff) begin
         wr_en = 1'b1;
         if (!hit_found_ff && rd_data.key == key_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_tag_in   = rd_data.tag;
         end
         // strict compare keeps the lowest index on ties
         if (aged > best_age_ff) begin
            best_age_in = aged;
            best_idx_in = rd_idx_ff;
            best_key_in = rd_data.key;
         end
      end

      // clear the hit entry's age, or install the request in the victim
      if (fix_fire) begin
         wr_en        = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_found_ff;
         if (hit_found_ff) begin
            wr_addr      = hit_idx_ff;
            wr_data      = '{key: key_ff, tag: hit_tag_ff, age: '0};
            rsp_slot_in  = SLOT_W'(hit_idx_ff);
            rsp_tag_in   = hit_tag_ff;
            rsp_evict_in = 1'b0;
            rsp_ekey_in  = '0;
         end else begin
            wr_addr      = best_idx_ff;
            wr_data      = '{key: key_ff, tag: tag_ff, age: '0};
            rsp_slot_in  = SLOT_W'(best_idx_ff);
            rsp_tag_in   = tag_ff;
            rsp_evict_in = (best_key_ff != '0);
            rsp_ekey_in  = best_key_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         hit_found_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_found_ff <= hit_found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      tag_ff       <= tag_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_tag_ff   <= hit_tag_in;
      best_age_ff  <= best_age_in;
      best_idx_ff  <= best_idx_in;
      best_key_ff  <= best_key_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_ekey_ff  <= rsp_ekey_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.slot        = rsp_slot_ff;
   assign rsp_ch.tag_out     = rsp_tag_ff;
   assign rsp_ch.evict_valid = rsp_evict_ff;
   assign rsp_ch.evicted_key = rsp_ekey_ff;

   `include "assert_macros.svh"

   // a result beat only appears right after the write-back step
   `ASSERT_HOLDS(a_rsp_from_fix, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIX,
      "result appeared outside write-back")
   // a stalled output register holds the sequencer in write-back
   `ASSERT_HOLDS(a_fix_waits,
      (state_ff == ST_FIX && rsp_valid_ff && !rsp_ch.ready) |=> state_ff == ST_FIX,
      "write-back overran a waiting result")
   // read sweep never reports an index past the table
   `ASSERT_NEVER(a_idx_range, rd_pend_ff && (rd_idx_ff > IDX_W'(ENTRIES - 1)),
      "read index beyond table")
   // a hit never reports an eviction, and an eviction always carries a live key
   `ASSERT_NEVER(a_evict_sane,
      rsp_valid_ff && rsp_evict_ff && (rsp_hit_ff || rsp_ekey_ff == '0),
      "bad eviction report")

endmodule
`default_nettype wire

// ===== rtl/alc_entry_store.sv =====
`default_nettype none
module alc_entry_store #(
   parameter  int ENTRIES = alc_pkg::ENTRIES_DEF,
   localparam int IDX_W   = $clog2(ENTRIES)
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    rd_en,
   input  wire [IDX_W-1:0]        rd_addr,
   output alc_pkg::entry_type     rd_data,
   input  wire                    wr_en,
   input  wire [IDX_W-1:0]        wr_addr,
   input  alc_pkg::entry_type     wr_data
);
   import alc_pkg::*;

   entry_type          mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   entry_type          rd_data_ff;
   logic               rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // never-written entries read as empty
   assign rd_data = rd_valid_ff ? rd_data_ff : ENTRY_RESET;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

// one reply beat as seen on the response channel
typedef struct packed {
   logic                       hit;
   logic [alc_pkg::SLOT_W-1:0] slot;
   logic [alc_pkg::TAG_W-1:0]  tag_out;
   logic                       evict_valid;
   logic [alc_pkg::KEY_W-1:0]  evicted_key;
} lookup_reply_type;

// mirrors the handle table and queues the reply each lookup must produce
class handle_lru_tracker;
   bit [alc_pkg::KEY_W-1:0] slot_key[alc_pkg::ENTRIES_DEF];
   bit [alc_pkg::TAG_W-1:0] slot_tag[alc_pkg::ENTRIES_DEF];
   bit [alc_pkg::AGE_W-1:0] slot_age[alc_pkg::ENTRIES_DEF];
   lookup_reply_type        pending[$];
   int faults, replies, hits, misses, releases, zero_hits;

   function void clear();
      foreach (slot_key[i]) begin
         slot_key[i] = '0;
         slot_tag[i] = '0;
         slot_age[i] = alc_pkg::AGE_MAX;
      end
      pending.delete();
      faults = 0;
      replies = 0;
      hits = 0;
      misses = 0;
      releases = 0;
      zero_hits = 0;
   endfunction

   function void note_lookup(bit [alc_pkg::KEY_W-1:0] key, bit [alc_pkg::TAG_W-1:0] new_tag);
      int                      found;
      int                      victim;
      bit [alc_pkg::AGE_W-1:0] oldest;
      lookup_reply_type        want;
      found = -1;
      want  = '0;
      for (int i = 0; i < alc_pkg::ENTRIES_DEF; i++)
         if (found < 0 && slot_key[i] == key) found = i;
      // every live age moves up, the empty marker stays put
      for (int i = 0; i < alc_pkg::ENTRIES_DEF; i++)
         if (slot_age[i] != alc_pkg::AGE_MAX) slot_age[i] = slot_age[i] + 1'b1;
      if (found >= 0) begin
         slot_age[found] = '0;
         want.hit     = 1'b1;
         want.slot    = found[alc_pkg::SLOT_W-1:0];
         want.tag_out = slot_tag[found];
         hits++;
         if (key == '0) zero_hits++;
      end else begin
         // oldest entry goes, lowest index wins a tie
         victim = 0;
         oldest = slot_age[0];
         for (int i = 1; i < alc_pkg::ENTRIES_DEF; i++) begin
            if (slot_age[i] > oldest) begin
               oldest = slot_age[i];
               victim = i;
            end
         end
         want.slot    = victim[alc_pkg::SLOT_W-1:0];
         want.tag_out = new_tag;
         if (slot_key[victim] != '0) begin
            want.evict_valid = 1'b1;
            want.evicted_key = slot_key[victim];
            releases++;
         end
         slot_key[victim] = key;
         slot_tag[victim] = new_tag;
         slot_age[victim] = '0;
         misses++;
      end
      pending.push_back(want);
   endfunction

   function void check_reply(lookup_reply_type got);
      lookup_reply_type want;
      replies++;
      if (pending.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("[%0t] reply %0d with no lookup outstanding: hit=%0b slot=%0d tag=%h",
                     $time, replies, got.hit, got.slot, got.tag_out);
         return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit || got.slot !== want.slot || got.tag_out !== want.tag_out ||
          got.evict_valid !== want.evict_valid || got.evicted_key !== want.evicted_key) begin
         faults++;
         if (faults <= 10) begin
            $display("[%0t] reply %0d mismatch", $time, replies);
            $display("   expected hit=%0b slot=%0d tag=%h evict=%0b key=%h",
                     want.hit, want.slot, want.tag_out, want.evict_valid, want.evicted_key);
            $display("   actual   hit=%0b slot=%0d tag=%h evict=%0b key=%h",
                     got.hit, got.slot, got.tag_out, got.evict_valid, got.evicted_key);
         end
      end
   endfunction
endclass

module tb_top;
   import alc_pkg::*;

   // cycles with no beat on either channel before the run is called hung
   localparam int STALL_LIMIT = 600;
   localparam int RANDOM_LOOKUPS = 1030;

   logic clock = 1'b0;
   logic reset = 1'b1;

   alc_req_if req_bus ();
   alc_rsp_if rsp_bus ();

   age_lru_handle_cache dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #6 clock = ~clock;

   handle_lru_tracker tracker;
   bit                calm = 1'b0;   // last stretch: no gaps, no stalls
   bit                gaps_on = 1'b1;
   int                quiet_cycles = 0;

   // beat monitor: lookups feed the tracker, replies are checked against it;
   // also the watchdog, since it already sees every beat
   always @(posedge clock) begin
      lookup_reply_type got;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_lookup(req_bus.key, req_bus.new_tag);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.hit         = rsp_bus.hit;
            got.slot        = rsp_bus.slot;
            got.tag_out     = rsp_bus.tag_out;
            got.evict_valid = rsp_bus.evict_valid;
            got.evicted_key = rsp_bus.evicted_key;
            tracker.check_reply(got);
            moved = 1'b1;
         end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no beat for %0d cycles, %0d replies outstanding",
                  $time, quiet_cycles, tracker.pending.size());
         $display("FAIL age_lru_handle_cache");
         $finish;
      end
   end

   // reply side backpressure: bursts of stall between bursts of ready
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // present one lookup and hold it until the block takes it
   task automatic drive_lookup(input bit [KEY_W-1:0] key, input bit [TAG_W-1:0] new_tag);
      req_bus.valid   <= 1'b1;
      req_bus.key     <= key;
      req_bus.new_tag <= new_tag;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // random idle burst on the request side
   task automatic pace_sender();
      if (!calm && gaps_on && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // stop sending until every reply in flight has come back
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending.size() != 0);
   endtask

   initial begin
      bit [KEY_W-1:0] dir_keys[20];
      bit [KEY_W-1:0] hot_keys[8];
      bit [KEY_W-1:0] key;
      bit [TAG_W-1:0] new_tag;
      int             pick;

      // directed walk: key zero on empty entries, filling all slots, then
      // hits, evictions of real keys and of the key-zero entry
      dir_keys = '{
         16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
         16'h5555, 16'hAAAA, 16'h0000, 16'h1234, 16'h8000,
         16'h7FFF, 16'h7FFF, 16'h0001, 16'h4321, 16'h0F0F,
         16'hF0F0, 16'h0000, 16'h2468, 16'h0000, 16'h1357
      };

      tracker = new();
      tracker.clear();
      req_bus.valid   <= 1'b0;
      req_bus.key     <= '0;
      req_bus.new_tag <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_keys[i]) begin
         case (i % 3)
            0: new_tag = '1;
            1: new_tag = '0;
            default: new_tag = $urandom();
         endcase
         pace_sender();
         drive_lookup(dir_keys[i], new_tag);
      end

      // back pressure point: table is idle before the random mix starts
      hold_until_drained();

      // a working set a bit larger than the table keeps hits and misses mixed
      foreach (hot_keys[i]) hot_keys[i] = KEY_W'($urandom_range(1, 16'hFFFF));

      for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
         if (n % 128 == 0) gaps_on = (n % 256 == 0);
         if (n == RANDOM_LOOKUPS - 150) calm = 1'b1;
         if (n == RANDOM_LOOKUPS / 2) hold_until_drained();
         if (n % 64 == 63) hot_keys[$urandom_range(0, 7)] = KEY_W'($urandom_range(1, 16'hFFFF));
         pick = $urandom_range(0, 99);
         if (pick < 65) key = hot_keys[$urandom_range(0, 7)];
         else if (pick < 72) key = '0;
         else key = KEY_W'($urandom_range(0, 16'hFFFF));
         pace_sender();
         drive_lookup(key, $urandom());
      end
      req_bus.valid <= 1'b0;

      // let the last replies land, then a few more cycles for strays
      do @(posedge clock); while (tracker.pending.size() != 0);
      repeat (ENTRIES_DEF + 8) @(posedge clock);

      $display("%0d lookups: %0d hits (%0d on key zero), %0d misses, %0d with a released key",
               tracker.hits + tracker.misses, tracker.hits, tracker.zero_hits,
               tracker.misses, tracker.releases);
      $display("%0d replies checked under random request gaps and reply stalls",
               tracker.replies);
      if (tracker.pending.size() != 0)
         $display("%0d replies never arrived", tracker.pending.size());
      if (tracker.faults == 0 && tracker.pending.size() == 0) begin
         $display("PASS age_lru_handle_cache");
      end else begin
         $display("FAIL age_lru_handle_cache");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/alc_pkg.sv
rtl/alc_if.sv
rtl/alc_entry_store.sv
rtl/age_lru_handle_cache.sv
tb/tb_top.sv
